// ===== src/data_rate_exponent_mantissa_search_assert.svh =====
// Assertion macros used by the top level of the symbol-rate search RTL.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef DATA_RATE_EXPONENT_MANTISSA_SEARCH_ASSERT_SVH
`define DATA_RATE_EXPONENT_MANTISSA_SEARCH_ASSERT_SVH

// Antecedent implies consequent, checked at every clock edge out of reset.
`define DREMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never hold out of reset.
`define DREMS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== src/drems_pkg.sv =====
// Package for the symbol-rate exponent/mantissa search: widths, constants and types.
// No dependencies.
package drems_pkg;

    localparam int RateW     = 22;
    localparam int XtalW     = 26;
    localparam int ExpN      = 16;
    localparam int ExpW      = 4;
    localparam int MantW     = 8;
    localparam int RateShift = 28;
    // The divider produces floor(rate * 2^29 / xtal), one extra bit for rounding.
    localparam int DivShift  = RateShift + 1;
    localparam int DivSteps  = RateW + DivShift;
    localparam int QW        = DivSteps;
    localparam int RateIdxW  = $clog2(RateW);
    localparam int TW        = MantW + 1;
    localparam int ProdW     = TW + XtalW;
    localparam int DiffW     = RateW + RateShift + 1;
    localparam int ErrW      = DiffW - RateShift;
    localparam int SelLevels = 4;
    localparam int Latency   = DivSteps + 2 + SelLevels;

    // Doubled quotient window that rounds to 256..511.
    localparam logic [QW-1:0] QLow  = QW'(511);
    localparam logic [QW-1:0] QHigh = QW'(1022);

    localparam logic [XtalW-1:0] XtalReset = XtalW'(26000000);
    localparam logic             RegCrystal = 1'b0;

    typedef struct packed {
        logic             vld;
        logic [QW-1:0]    quo;
        logic             rem_zero;
        logic [RateW-1:0] rate;
    } div_out_t;

    typedef struct packed {
        logic             vld;
        logic [ErrW-1:0]  err;
        logic [ExpW-1:0]  exp;
        logic [MantW-1:0] mant;
    } cand_t;

    // Lower exponent sits in a; it wins on equal error.
    function automatic cand_t pick(input cand_t a, input cand_t b);
        if (a.vld && (!b.vld || a.err <= b.err))
            return a;
        return b;
    endfunction

endpackage

// ===== src/drems_div.sv =====
// Pipelined restoring divider: floor(rate * 2^29 / crystal), one quotient bit per stage.
// Depends on drems_pkg.
module drems_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_vld,
    input  logic [drems_pkg::RateW-1:0]   rate,
    input  logic [drems_pkg::XtalW-1:0]   xtal,
    output drems_pkg::div_out_t           res
);
    import drems_pkg::*;

    logic [DivSteps-1:0] vld_reg;
    logic [XtalW-1:0]    rem_reg   [DivSteps];
    logic [XtalW-1:0]    rem_next  [DivSteps];
    logic [QW-1:0]       quo_reg   [DivSteps];
    logic [QW-1:0]       quo_next  [DivSteps];
    logic [RateW-1:0]    rate_reg  [DivSteps];
    logic [RateW-1:0]    rate_next [DivSteps];

    always_comb
    begin
        logic [XtalW-1:0]    pr;
        logic [QW-1:0]       pq;
        logic [RateW-1:0]    pt;
        logic [XtalW:0]      trial;
        logic [RateIdxW-1:0] ri;
        logic                dbit;
        for (int k = 0; k < DivSteps; k++)
        begin
            if (k == 0)
            begin
                pr = '0;
                pq = '0;
                pt = rate;
            end
            else
            begin
                pr = rem_reg[k-1];
                pq = quo_reg[k-1];
                pt = rate_reg[k-1];
            end
            ri   = (k < RateW) ? RateIdxW'(RateW - 1 - k) : '0;
            dbit = (k < RateW) ? pt[ri] : 1'b0;
            trial = {pr, dbit};
            if (trial >= {1'b0, xtal})
            begin
                rem_next[k] = XtalW'(trial - {1'b0, xtal});
                quo_next[k] = {pq[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[XtalW-1:0];
                quo_next[k] = {pq[QW-2:0], 1'b0};
            end
            rate_next[k] = pt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[DivSteps-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DivSteps; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            quo_reg[k]  <= quo_next[k];
            rate_reg[k] <= rate_next[k];
        end
    end

    assign res.vld      = vld_reg[DivSteps-1];
    assign res.quo      = quo_reg[DivSteps-1];
    assign res.rem_zero = (rem_reg[DivSteps-1] == '0);
    assign res.rate     = rate_reg[DivSteps-1];

endmodule

// ===== src/drems_eval.sv =====
// Sixteen exponent lanes: rounding, range check, achieved rate and error, two stages.
// Depends on drems_pkg.
module drems_eval
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  drems_pkg::div_out_t                   div,
    input  logic [drems_pkg::XtalW-1:0]           xtal,
    output logic                                  item_vld,
    output drems_pkg::cand_t [drems_pkg::ExpN-1:0] cands
);
    import drems_pkg::*;

    logic                 v1_reg;
    logic [ExpN-1:0]      ok_reg, ok_next;
    logic [MantW-1:0]     mant_reg [ExpN];
    logic [MantW-1:0]     mant_next[ExpN];
    logic [ProdW-1:0]     prod_reg [ExpN];
    logic [ProdW-1:0]     prod_next[ExpN];
    logic [RateW-1:0]     rate1_reg;
    logic                 v2_reg;
    cand_t [ExpN-1:0]     cand_reg, cand_next;

    // First stage: round the shifted quotient and form t * crystal.
    always_comb
    begin
        logic [QW-1:0] qs;
        logic [QW-1:0] lowmask;
        logic [10:0]   tfull;
        logic [TW-1:0] t;
        logic          tie;
        for (int e = 0; e < ExpN; e++)
        begin
            qs      = div.quo >> e;
            lowmask = QW'((QW'(1) << e) - QW'(1));
            tfull   = 11'(qs[9:0]) + 11'd1;
            t       = tfull[TW:1];
            // Exactly 255.5 would round up to 256 but is rejected.
            tie     = (qs == QLow) && ((div.quo & lowmask) == '0) && div.rem_zero;
            ok_next[e]   = (xtal != '0) && (qs >= QLow) && (qs <= QHigh) && !tie;
            mant_next[e] = t[MantW-1:0];
            prod_next[e] = ProdW'(t) * ProdW'(xtal);
        end
    end

    // Second stage: error of the achieved rate in whole Hz.
    always_comb
    begin
        logic [DiffW-1:0] ach;
        logic [DiffW-1:0] req;
        logic [DiffW-1:0] diff;
        req = DiffW'(rate1_reg) << RateShift;
        for (int e = 0; e < ExpN; e++)
        begin
            ach  = DiffW'(prod_reg[e]) << e;
            diff = (ach >= req) ? (ach - req) : (req - ach);
            cand_next[e].vld  = ok_reg[e];
            cand_next[e].err  = diff[DiffW-1:RateShift];
            cand_next[e].exp  = ExpW'(e);
            cand_next[e].mant = mant_reg[e];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= div.vld;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg    <= ok_next;
        rate1_reg <= div.rate;
        cand_reg  <= cand_next;
        for (int e = 0; e < ExpN; e++)
        begin
            mant_reg[e] <= mant_next[e];
            prod_reg[e] <= prod_next[e];
        end
    end

    assign item_vld = v2_reg;
    assign cands    = cand_reg;

endmodule

// ===== src/drems_sel.sv =====
// Registered four-level minimum tree over the sixteen lanes, lowest exponent on ties.
// Depends on drems_pkg.
module drems_sel
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_vld,
    input  drems_pkg::cand_t [drems_pkg::ExpN-1:0] cands,
    output logic                                   done,
    output logic [drems_pkg::ExpW-1:0]             rate_exponent,
    output logic [drems_pkg::MantW-1:0]            rate_mantissa
);
    import drems_pkg::*;

    cand_t [7:0] l1_reg;
    cand_t [3:0] l2_reg;
    cand_t [1:0] l3_reg;
    logic [SelLevels-1:0] vld_reg;
    cand_t                win;
    logic [ExpW-1:0]      exp_reg, exp_next;
    logic [MantW-1:0]     mant_reg, mant_next;

    always_comb
    begin
        win = pick(l3_reg[0], l3_reg[1]);
        if (vld_reg[SelLevels-2] && win.vld)
        begin
            exp_next  = win.exp;
            mant_next = win.mant;
        end
        else
        begin
            exp_next  = '0;
            mant_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            exp_reg  <= '0;
            mant_reg <= '0;
        end
        else
        begin
            vld_reg  <= {vld_reg[SelLevels-2:0], item_vld};
            exp_reg  <= exp_next;
            mant_reg <= mant_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
            l1_reg[i] <= pick(cands[2*i], cands[2*i+1]);
        for (int i = 0; i < 4; i++)
            l2_reg[i] <= pick(l1_reg[2*i], l1_reg[2*i+1]);
        for (int i = 0; i < 2; i++)
            l3_reg[i] <= pick(l2_reg[2*i], l2_reg[2*i+1]);
    end

    assign done          = vld_reg[SelLevels-1];
    assign rate_exponent = exp_reg;
    assign rate_mantissa = mant_reg;

endmodule

// ===== src/data_rate_exponent_mantissa_search.sv =====
// Top level of the symbol-rate exponent/mantissa search.
// Depends on drems_pkg, drems_div, drems_eval, drems_sel and the assertion header.
//
// Usage: write the crystal frequency in Hz to the register at byte address 0
// of the APB port (reset value 26 MHz), only while no request is in flight.
// A request transfer happens at a clock edge where start is high and busy is
// low. busy is never raised: the pipeline takes a new request in every cycle,
// so the sustained rate is one request per clock.
// Each request produces exactly one result transfer, done high for one cycle
// with rate_exponent and rate_mantissa. The result passes through the
// 51-stage restoring divider, one quotient bit per stage, followed by two
// lane stages (rounding and range check, then the achieved-rate error) and
// four levels of the registered minimum tree.
// Results leave in request order. The receiver cannot stall the block, so a
// result that is not taken in its one cycle is gone.
// Reset empties the pipeline (no result is produced for requests in flight)
// and restores the crystal register. Outside done the result ports read zero.
`include "data_rate_exponent_mantissa_search_assert.svh"
module data_rate_exponent_mantissa_search
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             start,
    output logic                             busy,
    input  logic [drems_pkg::RateW-1:0]      target_rate_hz,
    output logic                             done,
    output logic [drems_pkg::ExpW-1:0]       rate_exponent,
    output logic [drems_pkg::MantW-1:0]      rate_mantissa
);
    import drems_pkg::*;

    logic [XtalW-1:0] crystal_reg, crystal_next;
    logic             accept;
    div_out_t         div_res;
    logic             eval_vld;
    cand_t [ExpN-1:0] cands;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // The register is decoded on the word address bit only.
    always_comb
    begin
        crystal_next = crystal_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == RegCrystal))
            crystal_next = pwdata[XtalW-1:0];
    end

    assign prdata = (paddr[2] == RegCrystal) ? 32'(crystal_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crystal_reg <= XtalReset;
        else
            crystal_reg <= crystal_next;
    end

    drems_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (accept),
        .rate   (target_rate_hz),
        .xtal   (crystal_reg),
        .res    (div_res)
    );

    drems_eval u_eval
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .div      (div_res),
        .xtal     (crystal_reg),
        .item_vld (eval_vld),
        .cands    (cands)
    );

    drems_sel u_sel
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_vld      (eval_vld),
        .cands         (cands),
        .done          (done),
        .rate_exponent (rate_exponent),
        .rate_mantissa (rate_mantissa)
    );

    `DREMS_ASSERT_IMP(a_result_follows, accept, ##Latency done, "request without result")
    `DREMS_ASSERT_IMP(a_result_has_request, done, $past(accept, Latency),
        "result without request")
    `DREMS_ASSERT_IMP(a_zero_rate, accept && (target_rate_hz == '0),
        ##Latency (done && (rate_exponent == '0) && (rate_mantissa == '0)),
        "zero rate gave nonzero result")
    `DREMS_ASSERT_NEVER(a_idle_zero,
        !done && ((rate_exponent != '0) || (rate_mantissa != '0)),
        "result ports not zero while idle")

endmodule
